### hw/rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

  localparam int COUNT_WIDTH_DFLT = 16;
  localparam int UNIT_W           = 16;
  localparam int CONS_W           = 16;
  localparam int LIMIT_W          = 16;
  localparam int CP_W             = 21;

  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_END     = 3'd1,
    ST_STRAY   = 3'd2,
    ST_INVALID = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              is_term;
    status_t           status;
    logic [CONS_W-1:0] consumed;
    logic              last;
  } result_t;

  // one processed byte: number of results and the results themselves
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

### hw/rtl/u8u16_in_reg.sv
// ----------------------------------------------------------------------------
// u8u16_in_reg
// Input register: holds one accepted byte until the decoder takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_in_reg
  import u8u16_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       take,
  output logic            byte_valid,
  output logic [7:0]      byte_val
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r, byte_nxt;

  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
      byte_nxt  = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign byte_valid = valid_r;
  assign byte_val   = byte_r;

endmodule

`default_nettype wire

### hw/rtl/u8u16_core.sv
// ----------------------------------------------------------------------------
// u8u16_core
// Decoder state and single-pass decode of one byte into up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_core
  import u8u16_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DFLT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [LIMIT_W-1:0] cfg_wr_data,
  input  wire logic               byte_valid,
  input  wire logic [7:0]         byte_val,
  input  wire logic               can_push,
  output logic                    take,
  output push_t                   push
);

  localparam int CW    = COUNT_WIDTH;
  localparam int CMP_W = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;

  logic [CP_W-1:0]    pv_r, pv_nxt;
  logic [1:0]         pl_r, pl_nxt;
  logic               pa_r, pa_nxt;
  logic [CW-1:0]      bt_r, bt_nxt;
  logic [CW-1:0]      uw_r, uw_nxt;
  logic               halt_r, halt_nxt;
  logic [LIMIT_W-1:0] lim_r;

  logic [1:0]         n;
  result_t            r0, r1;
  logic [CP_W-1:0]    w, wofs;
  logic [CMP_W-1:0]   uw_ext, lim_ext, bt_ext;
  logic               lim_on, full1, full2, bad_cp;
  logic [CONS_W-1:0]  cons;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (x == '1) ? x : x + 1'b1;
  endfunction

  function automatic logic [CW-1:0] sat_add2(input logic [CW-1:0] x);
    return (x >= {{(CW-1){1'b1}}, 1'b0}) ? '1 : x + CW'(2);
  endfunction

  assign lim_on  = (lim_r != '0);
  assign uw_ext  = CMP_W'(uw_r);
  assign lim_ext = CMP_W'(lim_r - 1'b1);
  assign bt_ext  = CMP_W'(bt_r);
  assign full1   = lim_on && (uw_ext >= lim_ext);
  assign full2   = lim_on && ((uw_ext + CMP_W'(1)) >= lim_ext);
  assign cons    = (bt_ext > CMP_W'(16'hffff)) ? 16'hffff : bt_ext[CONS_W-1:0];
  assign w       = {pv_r[CP_W-7:0], byte_val[5:0]};
  assign wofs    = w - CP_W'(21'h10000);
  assign bad_cp  = ((w >= CP_W'(21'hd800)) && (w < CP_W'(21'he000))) ||
                   (w >= CP_W'(21'h110000));

  always_comb begin
    pv_nxt   = pv_r;
    pl_nxt   = pl_r;
    pa_nxt   = pa_r;
    bt_nxt   = bt_r;
    uw_nxt   = uw_r;
    halt_nxt = halt_r;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    if (halt_r) begin
      if (byte_val == 8'h00) begin
        pv_nxt   = '0;
        pl_nxt   = '0;
        pa_nxt   = 1'b0;
        bt_nxt   = '0;
        uw_nxt   = '0;
        halt_nxt = 1'b0;
      end
    end else if (byte_val == 8'h00) begin
      n           = 2'd1;
      r0.is_term  = 1'b1;
      r0.status   = ST_END;
      r0.consumed = cons;
      r0.last     = 1'b1;
      pv_nxt      = '0;
      pl_nxt      = '0;
      pa_nxt      = 1'b0;
      bt_nxt      = '0;
      uw_nxt      = '0;
    end else if (full1) begin
      n           = 2'd1;
      r0.is_term  = 1'b1;
      r0.status   = ST_FULL;
      r0.consumed = cons;
      r0.last     = 1'b1;
      halt_nxt    = 1'b1;
    end else if (byte_val < 8'h80) begin
      n       = 2'd1;
      r0.unit = UNIT_W'(byte_val);
      r0.last = 1'b1;
      uw_nxt  = sat_inc(uw_r);
      bt_nxt  = sat_inc(bt_r);
    end else if (byte_val < 8'hc0) begin
      if (!pa_r) begin
        n           = 2'd1;
        r0.is_term  = 1'b1;
        r0.status   = ST_STRAY;
        r0.consumed = cons;
        r0.last     = 1'b1;
        halt_nxt    = 1'b1;
      end else begin
        pv_nxt = w;
        if (pl_r > 2'd1) begin
          pl_nxt = pl_r - 2'd1;
          bt_nxt = sat_inc(bt_r);
        end else if (bad_cp) begin
          n           = 2'd1;
          r0.is_term  = 1'b1;
          r0.status   = ST_INVALID;
          r0.consumed = cons;
          r0.last     = 1'b1;
          halt_nxt    = 1'b1;
        end else if (w < CP_W'(21'h10000)) begin
          n       = 2'd1;
          r0.unit = w[UNIT_W-1:0];
          r0.last = 1'b1;
          uw_nxt  = sat_inc(uw_r);
          pa_nxt  = 1'b0;
          pl_nxt  = '0;
          bt_nxt  = sat_inc(bt_r);
        end else if (full2) begin
          n           = 2'd1;
          r0.is_term  = 1'b1;
          r0.status   = ST_FULL;
          r0.consumed = cons;
          r0.last     = 1'b1;
          halt_nxt    = 1'b1;
        end else begin
          n       = 2'd2;
          r0.unit = 16'hd800 + UNIT_W'(wofs[19:10]);
          r1.unit = 16'hdc00 + UNIT_W'(wofs[9:0]);
          r1.last = 1'b1;
          uw_nxt  = sat_add2(uw_r);
          pa_nxt  = 1'b0;
          pl_nxt  = '0;
          bt_nxt  = sat_inc(bt_r);
        end
      end
    end else begin
      if (byte_val < 8'he0) begin
        pv_nxt = CP_W'(byte_val[4:0]);
        pl_nxt = 2'd1;
      end else if (byte_val < 8'hf0) begin
        pv_nxt = CP_W'(byte_val[3:0]);
        pl_nxt = 2'd2;
      end else begin
        pv_nxt = CP_W'(byte_val[2:0]);
        pl_nxt = 2'd3;
      end
      pa_nxt = 1'b1;
      bt_nxt = sat_inc(bt_r);
    end
  end

  assign take     = byte_valid && ((n == 2'd0) || can_push);
  assign push.cnt = take ? n : 2'd0;
  assign push.r0  = r0;
  assign push.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      pl_r   <= '0;
      pa_r   <= 1'b0;
      bt_r   <= '0;
      uw_r   <= '0;
      halt_r <= 1'b0;
      lim_r  <= '0;
    end else begin
      if (take) begin
        pv_r   <= pv_nxt;
        pl_r   <= pl_nxt;
        pa_r   <= pa_nxt;
        bt_r   <= bt_nxt;
        uw_r   <= uw_nxt;
        halt_r <= halt_nxt;
      end
      if (cfg_wr_en) begin
        lim_r <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTH
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt == 2'd2) |-> (!push.r0.last && push.r1.last && !push.r0.is_term))
    else $error("surrogate pair framed wrong");

  a_term_alone: assert property (@(posedge clk) disable iff (!rst_n)
    ((push.cnt != 2'd0) && push.r0.is_term) |-> ((push.cnt == 2'd1) && push.r0.last))
    else $error("terminator not a single last result");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (take && halt_r && (byte_val == 8'h00)) |=> (!halt_r && (bt_r == '0) && !pa_r))
    else $error("NUL after stop did not re-arm");
`endif

endmodule

`default_nettype wire

### hw/rtl/u8u16_out_buf.sv
// ----------------------------------------------------------------------------
// u8u16_out_buf
// Two-entry result register feeding the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_out_buf
  import u8u16_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       can_push,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output result_t    head
);

  logic [1:0] cnt_r, cnt_nxt;
  result_t    head_r, head_nxt;
  result_t    tail_r, tail_nxt;
  logic       pop;

  assign pop      = (cnt_r != 2'd0) && out_tready;
  assign can_push = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (push.cnt != 2'd0) begin
      head_nxt = push.r0;
      tail_nxt = push.r1;
      cnt_nxt  = push.cnt;
    end else if (pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign head       = head_r;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> can_push)
    else $error("push into full result buffer");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |=> out_tvalid)
    else $error("pushed results not presented");
`endif

endmodule

`default_nettype wire

### hw/rtl/utf8_to_utf16_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// UTF-8 byte stream in, UTF-16 code units and string terminators out.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// in_      slave      tdata[7:0] byte
// out_     master     tdata unit/consumed, tuser term/status, tlast last
// cfg_     write      wr_data[15:0] output unit limit, 0 = unlimited
//
// A byte is decoded combinationally from the input register into the result
// register when the buffer has room; one result per cycle leaves the two-entry
// result buffer while out_tready is high, so the units of a surrogate pair leave
// one after the other. Bytes that give no result retire even while results wait.
// Reset clears all string state and the limit.
`default_nettype none

module utf8_to_utf16_transcoder_top
  import u8u16_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DFLT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,    // [7:0] in_byte
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [31:0]             out_tdata,   // [15:0] unit, [31:16] consumed
  output logic [3:0]              out_tuser,   // [0] is_terminator, [3:1] status
  output logic                    out_tlast,
  input  wire logic               cfg_wr_en,
  input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

  logic       take, byte_valid, can_push;
  logic [7:0] byte_val;
  push_t      push;
  result_t    head;

  u8u16_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_val   (byte_val)
  );

  u8u16_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (byte_valid),
    .byte_val    (byte_val),
    .can_push    (can_push),
    .take        (take),
    .push        (push)
  );

  u8u16_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .can_push   (can_push),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = {head.consumed, head.unit};
  assign out_tuser = {head.status, head.is_term};
  assign out_tlast = head.last;

endmodule

`default_nettype wire

### dv/utf8_to_utf16_transcoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top_tb
// Self-checking bench for the UTF-8 to UTF-16 transcoder. A behavioral
// decoder predicts the code units and terminators for every byte accepted.
// Each result transaction is checked against the oldest prediction. Tests
// cover directed corner cases, output limits, and random phases under
// several output limits. Both sides idle at random but in the last phase.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder_top_tb;
  import u8u16_pkg::*;

  localparam int          CLK_PERIOD  = 20;
  localparam int          CYCLE_LIMIT = 500_000;
  localparam logic [7:0]  CONT_MIN    = 8'h80;
  localparam logic [7:0]  LEAD2_MIN   = 8'hc0;
  localparam logic [7:0]  LEAD3_MIN   = 8'he0;
  localparam logic [7:0]  LEAD4_MIN   = 8'hf0;
  localparam logic [15:0] COUNT_SAT   = 16'hffff;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata    = 8'h00;  // [7:0] in_byte
  logic                 out_tvalid;
  logic                 out_tready  = 1'b0;
  logic [31:0]          out_tdata;            // [15:0] unit, [31:16] consumed
  logic [3:0]           out_tuser;            // [0] is_terminator, [3:1] status
  logic                 out_tlast;
  logic                 cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wr_data = '0;

  // decoder state
  logic [CP_W-1:0]      cp_acc;
  logic [1:0]           conts_left;
  logic                 seq_open;
  logic [15:0]          byte_cnt;
  logic [15:0]          unit_cnt;
  logic                 stopped;
  logic [15:0]          unit_limit;

  result_t              expected_units[$];
  int                   err_count   = 0;
  int                   bytes_sent  = 0;
  int                   cycle_count = 0;
  int                   out_hold    = 0;
  bit                   in_idle_en  = 1'b1;
  bit                   out_idle_en = 1'b1;

  utf8_to_utf16_transcoder_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_string();
    cp_acc     = '0;
    conts_left = '0;
    seq_open   = 1'b0;
    byte_cnt   = '0;
    unit_cnt   = '0;
  endfunction

  function automatic void push_result(logic [15:0] u, logic term, status_t st,
                                      logic [15:0] cons, logic lst);
    result_t r;
    r.unit     = u;
    r.is_term  = term;
    r.status   = st;
    r.consumed = cons;
    r.last     = lst;
    expected_units.push_back(r);
  endfunction

  function automatic void push_unit(logic [15:0] u, logic lst);
    push_result(u, 1'b0, ST_DATA, '0, lst);
    if (unit_cnt != COUNT_SAT) unit_cnt++;
  endfunction

  function automatic void halt_string(status_t st);
    push_result('0, 1'b1, st, byte_cnt, 1'b1);
    stopped = 1'b1;
  endfunction

  function automatic void count_byte();
    if (byte_cnt != COUNT_SAT) byte_cnt++;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [CP_W-1:0] w;
    logic [CP_W-1:0] off;
    if (stopped) begin
      if (b == 8'h00) begin
        clear_string();
        stopped = 1'b0;
      end
      return;
    end
    if (b == 8'h00) begin
      push_result('0, 1'b1, ST_END, byte_cnt, 1'b1);
      clear_string();
      return;
    end
    if (unit_limit != 0 && int'(unit_cnt) >= int'(unit_limit) - 1) begin
      halt_string(ST_FULL);
      return;
    end
    if (b < CONT_MIN) begin
      push_unit({8'h00, b}, 1'b1);
      count_byte();
    end else if (b < LEAD2_MIN) begin
      if (!seq_open) begin
        halt_string(ST_STRAY);
        return;
      end
      w = {cp_acc[CP_W-7:0], b[5:0]};
      cp_acc = w;
      if (conts_left > 2'd1) begin
        conts_left--;
        count_byte();
        return;
      end
      if ((w >= 21'h00d800 && w < 21'h00e000) || w >= 21'h110000) begin
        halt_string(ST_INVALID);
        return;
      end
      if (w < 21'h010000) begin
        push_unit(w[15:0], 1'b1);
      end else begin
        if (unit_limit != 0 && int'(unit_cnt) + 1 >= int'(unit_limit) - 1) begin
          halt_string(ST_FULL);
          return;
        end
        off = w - 21'h010000;
        push_unit(16'hd800 + {6'd0, off[19:10]}, 1'b0);
        push_unit(16'hdc00 + {6'd0, off[9:0]}, 1'b1);
      end
      seq_open   = 1'b0;
      conts_left = '0;
      count_byte();
    end else begin
      if (b < LEAD3_MIN) begin
        cp_acc     = {16'd0, b[4:0]};
        conts_left = 2'd1;
      end else if (b < LEAD4_MIN) begin
        cp_acc     = {17'd0, b[3:0]};
        conts_left = 2'd2;
      end else begin
        cp_acc     = {18'd0, b[2:0]};
        conts_left = 2'd3;
      end
      seq_open = 1'b1;
      count_byte();
    end
  endfunction

  // ------------------------------------------------------------------ drivers

  task automatic send_byte(input logic [7:0] b);
    if (in_idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic send_code_point(input logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      send_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      send_byte({3'b110, cp[10:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      send_byte({4'b1110, cp[15:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else begin
      send_byte({5'b11110, cp[20:18]});
      send_byte({2'b10, cp[17:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic write_limit(input logic [15:0] v);
    in_tvalid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    unit_limit = v;
  endtask

  // ------------------------------------------------------------ result side

  always @(posedge clk) begin
    if (out_idle_en && out_hold == 0 && $urandom_range(0, 7) == 0)
      out_hold = $urandom_range(1, 13);
    if (out_hold > 0) begin
      out_hold--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_units.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual %h/%h/%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_units.pop_front();
        check_field("unit", 32'(want.unit), 32'(out_tdata[15:0]));
        check_field("consumed", 32'(want.consumed), 32'(out_tdata[31:16]));
        check_field("is_terminator", 32'(want.is_term), 32'(out_tuser[0]));
        check_field("status", 32'(want.status), 32'(out_tuser[3:1]));
        check_field("last", 32'(want.last), 32'(out_tlast));
      end
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_passthrough();
    send_bytes('{8'h41, 8'h7f, 8'h00});
  endtask

  task automatic test_sequences();
    send_bytes('{8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98, 8'h80,
                 8'hc0, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h00});
  endtask

  task automatic test_errors();
    // stray continuation, dropped byte, re-arm
    send_bytes('{8'h80, 8'h41, 8'h00});
    // lead replaced by lead, ASCII inside a sequence, then a surrogate value
    send_bytes('{8'hc3, 8'he2, 8'h41, 8'ha0, 8'h80, 8'hed, 8'ha0, 8'h80, 8'h00});
    // wide leads keep three bits
    send_bytes('{8'hf8, 8'h80, 8'h80, 8'h80, 8'hff, 8'h80, 8'h80, 8'h80, 8'h00});
  endtask

  task automatic test_output_limit();
    write_limit(16'd1);
    send_bytes('{8'h41, 8'h00, 8'h00});
    write_limit(16'd3);
    send_bytes('{8'h41, 8'hf0, 8'h9f, 8'h98, 8'h80, 8'h00});
    write_limit(16'd2);
    send_bytes('{8'h41, 8'h00});
  endtask

  task automatic send_random_string_part();
    logic [CP_W-1:0] cp;
    if ($urandom_range(0, 11) == 0) begin
      send_byte(8'h00);
      return;
    end
    case ($urandom_range(0, 11))
      0, 1:          send_code_point(21'($urandom_range(1, 'h7f)));
      2, 3:          send_code_point(21'($urandom_range('h80, 'h7ff)));
      4, 5: begin
        cp = 21'($urandom_range('h800, 'hf7ff));
        if (cp >= 21'hd800) cp = cp + 21'h800;
        send_code_point(cp);
      end
      6, 7:          send_code_point(21'($urandom_range('h10000, 'h10ffff)));
      8:             send_byte(8'($urandom_range(0, 255)));
      9:             send_byte(8'($urandom_range('hc0, 'hff)));
      10: begin
        if ($urandom_range(0, 1) == 0)
          send_code_point(21'($urandom_range('hd800, 'hdfff)));
        else
          send_code_point(21'($urandom_range('h110000, 'h1fffff)));
      end
      default: begin
        send_byte({7'b1100000, 1'($urandom_range(0, 1))});
        send_byte({2'b10, 6'($urandom_range(0, 63))});
      end
    endcase
  endtask

  task automatic test_random_phases();
    logic [15:0] limits[7];
    int          target;
    limits = '{16'd0, 16'd2, 16'd3, 16'($urandom_range(4, 24)), 16'hffff,
               16'($urandom_range(0, 65535)), 16'd0};
    foreach (limits[p]) begin
      if (p == 6) begin
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
      end
      write_limit(limits[p]);
      target = bytes_sent + 300;
      while (bytes_sent < target) send_random_string_part();
    end
  endtask

  initial begin
    clear_string();
    stopped    = 1'b0;
    unit_limit = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_sequences();
    test_errors();
    test_output_limit();
    test_random_phases();

    in_tvalid <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/u8u16_pkg.sv
hw/rtl/u8u16_in_reg.sv
hw/rtl/u8u16_core.sv
hw/rtl/u8u16_out_buf.sv
hw/rtl/utf8_to_utf16_transcoder_top.sv
dv/utf8_to_utf16_transcoder_top_tb.sv
